>>> sv/clcd_pkg.sv
// clcd_pkg: shared types, constants and tables for the character LCD nibble interface.
// Used by every module of the block; depends on nothing.
`default_nettype none

package clcd_pkg;

    // Geometry and protocol constants
    localparam int MAX_LINES      = 4;
    localparam int MAX_COLUMNS    = 40;
    localparam int INIT_BYTES     = 5;
    localparam int MAX_STROBES    = 2 * INIT_BYTES;
    localparam int STEP_W         = $clog2(MAX_STROBES);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int LINE_W         = 3;
    localparam int COL_W          = 6;

    localparam logic [7:0]  DDRAM_SET       = 8'h80;
    localparam logic [15:0] CMD_WAIT_RESET  = 16'd2000;
    localparam logic [15:0] DATA_WAIT_RESET = 16'd1;
    localparam logic [5:0]  COLUMNS_RESET   = 6'd20;
    localparam logic [2:0]  LINES_RESET     = 3'd4;

    // Register map (index into the register file)
    localparam logic [1:0] REG_CMD_WAIT  = 2'd0;
    localparam logic [1:0] REG_DATA_WAIT = 2'd1;
    localparam logic [1:0] REG_COLUMNS   = 2'd2;
    localparam logic [1:0] REG_LINES     = 2'd3;

    // Input item
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] value;
        logic       message_start;
    } item_t;

    // One strobe on the bus
    typedef struct packed {
        logic        reg_select;
        logic [3:0]  nibble;
        logic [15:0] wait_after_us;
        logic        last;
    } strobe_t;

    // Input op codes
    typedef enum logic [1:0] {
        OP_CMD  = 2'd0,
        OP_DATA = 2'd1,
        OP_MSG  = 2'd2,
        OP_INIT = 2'd3
    } op_t;

    // Work handed from the front to the back
    typedef enum logic [1:0] {
        JOB_CMD,
        JOB_DATA,
        JOB_INIT,
        JOB_LINE
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] value;
        logic [7:0] addr;
    } job_t;

    function automatic logic [7:0] line_base(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h00;
            2'd1:    b = 8'h40;
            2'd2:    b = 8'h14;
            2'd3:    b = 8'h54;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'b0011_0011;
            3'd1:    b = 8'b0011_0010;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h0F;
            3'd4:    b = 8'h04;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> sv/clcd_queue.sv
// clcd_queue: two-entry job queue between the front and the back.
// Depends on clcd_pkg.
`default_nettype none

module clcd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire clcd_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output clcd_pkg::job_t     head
);
    import clcd_pkg::*;

    job_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

>>> sv/clcd_front.sv
// clcd_front: accepts input items, keeps the message layout and classifies each item into a job.
// Depends on clcd_pkg.
`default_nettype none

module clcd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire clcd_pkg::item_t item,
    input  wire logic [5:0]    columns,
    input  wire logic [2:0]    lines_used,
    input  wire logic          queue_full,
    output logic               push,
    output clcd_pkg::job_t     push_job
);
    import clcd_pkg::*;

    logic [LINE_W-1:0] line_index_reg, line_index_next;
    logic [COL_W-1:0]  column_count_reg, column_count_next;

    logic              accept;
    logic [COL_W-1:0]  cols;
    logic [LINE_W-1:0] lines;
    logic [LINE_W-1:0] line_eff;
    logic [COL_W-1:0]  col_eff;
    logic [COL_W-1:0]  col_inc;
    logic              room;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;

    always_comb
    begin
        // clamp the layout registers to the legal range
        if (columns == '0)
            cols = COL_W'(1);
        else if (columns > COL_W'(MAX_COLUMNS))
            cols = COL_W'(MAX_COLUMNS);
        else
            cols = columns;

        if (lines_used == '0)
            lines = LINE_W'(1);
        else if (lines_used > LINE_W'(MAX_LINES))
            lines = LINE_W'(MAX_LINES);
        else
            lines = lines_used;

        line_eff = item.message_start ? '0 : line_index_reg;
        col_eff  = item.message_start ? '0 : column_count_reg;
        col_inc  = col_eff + 1'b1;
        room     = (line_eff < lines);

        line_index_next   = line_index_reg;
        column_count_next = column_count_reg;
        push              = 1'b0;
        push_job.value    = item.value;
        push_job.addr     = DDRAM_SET | line_base(line_eff[1:0]);
        push_job.kind     = JOB_CMD;

        case (op_t'(item.op))
            OP_CMD:
            begin
                push_job.kind = JOB_CMD;
                push          = accept;
            end
            OP_DATA:
            begin
                push_job.kind = JOB_DATA;
                push          = accept;
            end
            OP_INIT:
            begin
                push_job.kind = JOB_INIT;
                push          = accept;
            end
            OP_MSG:
            begin
                // line start sends the address command first
                push_job.kind = (col_eff == '0) ? JOB_LINE : JOB_DATA;
                push          = accept && room;
                if (accept)
                begin
                    line_index_next   = line_eff;
                    column_count_next = col_eff;
                    if (room)
                    begin
                        if (col_inc >= cols)
                        begin
                            column_count_next = '0;
                            line_index_next   = line_eff + 1'b1;
                        end
                        else
                        begin
                            column_count_next = col_inc;
                        end
                    end
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_index_reg   <= '0;
            column_count_reg <= '0;
        end
        else
        begin
            line_index_reg   <= line_index_next;
            column_count_reg <= column_count_next;
        end
    end

`ifndef SYNTHESIS
    a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_index_reg <= LINE_W'(MAX_LINES))
        else $error("line index ran past the last display line");
`endif

endmodule

`default_nettype wire

>>> sv/clcd_back.sv
// clcd_back: expands the job at the queue head into nibble strobes, one per cycle while strobe_stall is low.
// Depends on clcd_pkg.
`default_nettype none

module clcd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire clcd_pkg::job_t head,
    output logic               pop,
    input  wire logic [15:0]   command_wait_us,
    input  wire logic [15:0]   data_wait_us,
    output logic               strobe_valid,
    input  wire logic          strobe_stall,
    output clcd_pkg::strobe_t  strobe
);
    import clcd_pkg::*;

    logic              strobe_valid_reg, strobe_valid_next;
    strobe_t           strobe_reg, strobe_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic              advance;
    logic [2:0]        byte_idx;
    logic [2:0]        last_byte;
    logic [7:0]        cur_byte;
    logic              rs;
    logic              final_strobe;

    assign advance      = !strobe_valid_reg || !strobe_stall;
    assign strobe_valid = strobe_valid_reg;
    assign strobe       = strobe_reg;

    always_comb
    begin
        byte_idx = step_reg[STEP_W-1:1];

        case (head.kind)
            JOB_CMD:
            begin
                rs        = 1'b0;
                cur_byte  = head.value;
                last_byte = 3'd0;
            end
            JOB_DATA:
            begin
                rs        = 1'b1;
                cur_byte  = head.value;
                last_byte = 3'd0;
            end
            JOB_INIT:
            begin
                rs        = 1'b0;
                cur_byte  = init_byte(byte_idx);
                last_byte = 3'(INIT_BYTES - 1);
            end
            JOB_LINE:
            begin
                rs        = (byte_idx != '0);
                cur_byte  = (byte_idx == '0) ? head.addr : head.value;
                last_byte = 3'd1;
            end
            default:
            begin
                rs        = 1'b0;
                cur_byte  = head.value;
                last_byte = 3'd0;
            end
        endcase

        final_strobe = step_reg[0] && (byte_idx == last_byte);

        strobe_next.reg_select    = rs;
        strobe_next.nibble        = step_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
        strobe_next.wait_after_us = !step_reg[0] ? 16'd0
                                  : (rs ? data_wait_us : command_wait_us);
        strobe_next.last          = final_strobe;

        strobe_valid_next = strobe_valid_reg;
        step_next         = step_reg;
        pop               = 1'b0;
        if (advance)
        begin
            strobe_valid_next = head_valid;
            if (head_valid)
            begin
                pop       = final_strobe;
                step_next = final_strobe ? '0 : step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_valid_reg <= 1'b0;
            step_reg         <= '0;
        end
        else
        begin
            strobe_valid_reg <= strobe_valid_next;
            step_reg         <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && head_valid)
        begin
            strobe_reg <= strobe_next;
        end
    end

`ifndef SYNTHESIS
    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (strobe_valid_reg && strobe_reg.last))
        else $error("job retired without a final strobe");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < STEP_W'(MAX_STROBES))
        else $error("strobe counter out of range");
`endif

endmodule

`default_nettype wire

>>> sv/char_lcd_nibble_interface.sv
// char_lcd_nibble_interface: top level of the 4-bit character LCD driver.
// Holds the APB register file and joins clcd_front, clcd_queue and clcd_back; uses clcd_pkg.
// An item's job is registered in the job queue, then its strobes in the output register.
// Throughput: one strobe per cycle while strobe_stall is low, so a raw byte is 2 strobes,
//   a message character at a line start 4, other message characters 2 and init 10.
// The two-entry job queue lets the front take new items while the back is still strobing.
// Reset (rst_n low, asynchronous) empties the queue and output, zeroes the layout state
//   and loads the register reset values (2000 us, 1 us, 20 columns, 4 lines).
`default_nettype none

module char_lcd_nibble_interface (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // input item channel
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire clcd_pkg::item_t item,
    // strobe channel
    output logic               strobe_valid,
    input  wire logic          strobe_stall,
    output clcd_pkg::strobe_t  strobe,
    // configuration port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import clcd_pkg::*;

    // Register file
    logic [15:0] cmd_wait_reg;
    logic [15:0] data_wait_reg;
    logic [5:0]  columns_reg;
    logic [2:0]  lines_reg;

    logic        cfg_write;
    logic [1:0]  reg_idx;

    // Front to queue, queue to back
    logic        push;
    job_t        push_job;
    logic        queue_full;
    logic        pop;
    logic        head_valid;
    job_t        head;

    // APB: no wait states; a write lands on the access phase
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_wait_reg  <= CMD_WAIT_RESET;
            data_wait_reg <= DATA_WAIT_RESET;
            columns_reg   <= COLUMNS_RESET;
            lines_reg     <= LINES_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_CMD_WAIT:  cmd_wait_reg  <= pwdata[15:0];
                REG_DATA_WAIT: data_wait_reg <= pwdata[15:0];
                REG_COLUMNS:   columns_reg   <= pwdata[5:0];
                REG_LINES:     lines_reg     <= pwdata[2:0];
                default:       cmd_wait_reg  <= cmd_wait_reg;
            endcase
        end
    end

    // Read back the stored value, zero extended
    always_comb
    begin
        case (reg_idx)
            REG_CMD_WAIT:  prdata = {16'd0, cmd_wait_reg};
            REG_DATA_WAIT: prdata = {16'd0, data_wait_reg};
            REG_COLUMNS:   prdata = {26'd0, columns_reg};
            REG_LINES:     prdata = {29'd0, lines_reg};
            default:       prdata = '0;
        endcase
    end

    // Front: take items, track the message layout, drop characters past the last line
    clcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .columns    (columns_reg),
        .lines_used (lines_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Queue: hold classified jobs; the front waits on the bus strobes only when full
    clcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back: expand each job into high/low nibble strobes with their waits
    clcd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .command_wait_us (cmd_wait_reg),
        .data_wait_us    (data_wait_reg),
        .strobe_valid    (strobe_valid),
        .strobe_stall    (strobe_stall),
        .strobe          (strobe)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// tb_top: self-checking testbench for char_lcd_nibble_interface.
// Predicts every nibble strobe from the input transfers and checks each one in order.
// Depends on clcd_pkg and the char_lcd_nibble_interface RTL only.
`timescale 1ns / 1ps

module tb_top;
    import clcd_pkg::*;

    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 30;
    localparam int QUIET_PHASE    = 2;
    localparam int ITEM_W         = $bits(item_t);

    // Bytes of the power-up sequence and DDRAM base address of each display line
    localparam logic [7:0] INIT_SEQ [INIT_BYTES] = '{8'h33, 8'h32, 8'h28, 8'h0F, 8'h04};
    localparam logic [7:0] LINE_BASE [MAX_LINES] = '{8'h00, 8'h40, 8'h14, 8'h54};

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    item_t       item         = '0;
    logic        strobe_valid;
    logic        strobe_stall = 1'b0;
    strobe_t     strobe;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [3:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the register file
    logic [15:0] cfg_cmd_wait  = CMD_WAIT_RESET;
    logic [15:0] cfg_data_wait = DATA_WAIT_RESET;
    logic [5:0]  cfg_columns   = COLUMNS_RESET;
    logic [2:0]  cfg_lines     = LINES_RESET;

    // Shadow copy of the message layout position
    logic [2:0]  cur_line = '0;
    logic [5:0]  cur_col  = '0;

    strobe_t     pending_strobes[$];
    int          errors  = 0;
    bit          idle_on = 1'b1;

    char_lcd_nibble_interface uut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void note_failure(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function automatic item_t pack_item(input op_t op, input logic [7:0] v, input logic s);
        item_t it;
        it.op            = op;
        it.value         = v;
        it.message_start = s;
        return it;
    endfunction

    // Queue the two strobes of one byte: high nibble with no wait, then low nibble
    // carrying the wait that belongs to the byte's register select.
    function automatic void queue_byte(input logic rs, input logic [7:0] b, input logic fin);
        strobe_t s;
        s.reg_select    = rs;
        s.nibble        = b[7:4];
        s.wait_after_us = '0;
        s.last          = 1'b0;
        pending_strobes.push_back(s);
        s.nibble        = b[3:0];
        s.wait_after_us = rs ? cfg_data_wait : cfg_cmd_wait;
        s.last          = fin;
        pending_strobes.push_back(s);
    endfunction

    // Work out every strobe that one accepted item causes and advance the layout state
    function automatic void predict_strobes(input item_t it);
        logic [5:0] cols;
        logic [2:0] lines;
        cols  = (cfg_columns == 0) ? 6'd1 :
                (cfg_columns > MAX_COLUMNS) ? 6'(MAX_COLUMNS) : cfg_columns;
        lines = (cfg_lines == 0) ? 3'd1 :
                (cfg_lines > MAX_LINES) ? 3'(MAX_LINES) : cfg_lines;
        case (it.op)
            OP_CMD:  queue_byte(1'b0, it.value, 1'b1);
            OP_DATA: queue_byte(1'b1, it.value, 1'b1);
            OP_INIT:
                for (int i = 0; i < INIT_BYTES; i++)
                    queue_byte(1'b0, INIT_SEQ[i], i == INIT_BYTES - 1);
            default:
            begin
                // A new message restarts at the top left corner
                if (it.message_start)
                begin
                    cur_line = '0;
                    cur_col  = '0;
                end
                // Once every used line is full, further characters are dropped
                if (cur_line < lines)
                begin
                    if (cur_col == 0)
                        queue_byte(1'b0, DDRAM_SET | LINE_BASE[cur_line[1:0]], 1'b0);
                    queue_byte(1'b1, it.value, 1'b1);
                    cur_col = cur_col + 6'd1;
                    if (cur_col >= cols)
                    begin
                        cur_col  = '0;
                        cur_line = cur_line + 3'd1;
                    end
                end
            end
        endcase
    endfunction

    // Offer one item, hold it until the transfer, then predict its strobes.
    // Idle cycles drop valid and scramble the payload so gaps fall anywhere.
    task automatic send_item(input item_t it);
        logic [ITEM_W-1:0] noise;
        while (idle_on && $urandom_range(0, 99) < 15)
        begin
            noise      = ITEM_W'($urandom);
            item_valid <= 1'b0;
            item       <= item_t'(noise);
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        predict_strobes(it);
    endtask

    // Drop valid, wait for every predicted strobe, then let the pipeline empty out
    // in case the last item caused no strobe at all.
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_strobes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register over APB, update the shadow copy, then read it back.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        logic [31:0] masked;
        case (idx)
            REG_COLUMNS: masked = {26'd0, val[5:0]};
            REG_LINES:   masked = {29'd0, val[2:0]};
            default:     masked = {16'd0, val};
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= masked;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_CMD_WAIT:  cfg_cmd_wait  = masked[15:0];
            REG_DATA_WAIT: cfg_data_wait = masked[15:0];
            REG_COLUMNS:   cfg_columns   = masked[5:0];
            default:       cfg_lines     = masked[2:0];
        endcase
        // Go straight into the setup phase of the read-back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== masked)
            note_failure($sformatf("register %0d reads %h, expected %h", idx, prdata, masked));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Raw bytes at the value extremes; message start on a raw op must be ignored
    task automatic test_raw_bytes();
        send_item(pack_item(OP_CMD, 8'h00, 1'b0));
        send_item(pack_item(OP_CMD, 8'hFF, 1'b1));
        send_item(pack_item(OP_DATA, 8'h00, 1'b1));
        send_item(pack_item(OP_DATA, 8'hFF, 1'b0));
    endtask

    // Init ignores both the value and the message start
    task automatic test_init_sequence();
        send_item(pack_item(OP_INIT, 8'hFF, 1'b1));
    endtask

    // Both waits at their extremes, each way round
    task automatic test_wait_extremes();
        settle();
        write_reg(REG_CMD_WAIT, 16'hFFFF);
        write_reg(REG_DATA_WAIT, 16'h0000);
        send_item(pack_item(OP_CMD, 8'h5A, 1'b0));
        send_item(pack_item(OP_DATA, 8'hA5, 1'b0));
        settle();
        write_reg(REG_CMD_WAIT, 16'h0000);
        write_reg(REG_DATA_WAIT, 16'hFFFF);
        send_item(pack_item(OP_CMD, 8'hC3, 1'b0));
        send_item(pack_item(OP_DATA, 8'h3C, 1'b0));
    endtask

    // Line wrap, full display, restart by message start, and clamped geometry
    task automatic test_message_layout();
        settle();
        write_reg(REG_COLUMNS, 16'd2);
        write_reg(REG_LINES, 16'd2);
        send_item(pack_item(OP_MSG, "A", 1'b1));
        send_item(pack_item(OP_MSG, "B", 1'b0));
        send_item(pack_item(OP_MSG, "C", 1'b0));
        send_item(pack_item(OP_MSG, "D", 1'b0));
        send_item(pack_item(OP_MSG, "E", 1'b0));
        send_item(pack_item(OP_MSG, "F", 1'b1));
        // Zero columns and zero lines behave as one of each
        settle();
        write_reg(REG_COLUMNS, 16'd0);
        write_reg(REG_LINES, 16'd0);
        send_item(pack_item(OP_MSG, "x", 1'b1));
        send_item(pack_item(OP_MSG, "y", 1'b0));
        // Oversized geometry clamps to forty columns and four lines
        settle();
        write_reg(REG_COLUMNS, 16'd63);
        write_reg(REG_LINES, 16'd7);
        send_item(pack_item(OP_MSG, "z", 1'b1));
        send_item(pack_item(OP_MSG, "w", 1'b0));
    endtask

    // Random geometry and waits per phase; mostly message text, so lines fill up
    task automatic test_random_traffic();
        op_t  op;
        logic start;
        int   pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            case ($urandom_range(0, 3))
                0:       write_reg(REG_CMD_WAIT, 16'h0000);
                1:       write_reg(REG_CMD_WAIT, 16'hFFFF);
                default: write_reg(REG_CMD_WAIT, 16'($urandom));
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(REG_DATA_WAIT, 16'h0000);
                1:       write_reg(REG_DATA_WAIT, 16'hFFFF);
                default: write_reg(REG_DATA_WAIT, 16'($urandom));
            endcase
            // Keep the columns small most of the time so line starts come often
            case ($urandom_range(0, 5))
                0:       write_reg(REG_COLUMNS, 16'd0);
                1:       write_reg(REG_COLUMNS, 16'd1);
                2:       write_reg(REG_COLUMNS, 16'(MAX_COLUMNS));
                3:       write_reg(REG_COLUMNS, 16'($urandom_range(41, 63)));
                default: write_reg(REG_COLUMNS, 16'($urandom_range(1, 8)));
            endcase
            write_reg(REG_LINES, 16'($urandom_range(0, 7)));
            // One phase runs flat out on both channels
            idle_on = (phase != QUIET_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    op    = OP_MSG;
                    start = ($urandom_range(0, 15) == 0);
                end
                else
                begin
                    op    = (pick < 75) ? OP_CMD : (pick < 90) ? OP_DATA : OP_INIT;
                    start = 1'($urandom);
                end
                send_item(pack_item(op, 8'($urandom), start));
            end
            idle_on = 1'b1;
        end
    endtask

    // Strobe receiver: stall at random while idling is on
    always @(posedge clk)
        strobe_stall <= idle_on && ($urandom_range(0, 99) < 15);

    // Compare every strobe transfer with the oldest prediction
    always @(posedge clk)
    begin
        strobe_t want;
        if (rst_n && strobe_valid && !strobe_stall)
        begin
            if (pending_strobes.size() == 0)
                note_failure($sformatf("unexpected strobe rs=%0b nibble=%h wait=%0d last=%0b",
                             strobe.reg_select, strobe.nibble, strobe.wait_after_us,
                             strobe.last));
            else
            begin
                want = pending_strobes.pop_front();
                if (strobe !== want)
                    note_failure($sformatf(
                        "strobe rs=%0b nibble=%h wait=%0d last=%0b, expected %0b %h %0d %0b",
                        strobe.reg_select, strobe.nibble, strobe.wait_after_us, strobe.last,
                        want.reg_select, want.nibble, want.wait_after_us, want.last));
            end
        end
    end

    // Watchdog: end the run if no transfer happens on either channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (strobe_valid && !strobe_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        // Hold reset, then release it once for the whole run
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_raw_bytes();
        test_init_sequence();
        test_wait_extremes();
        test_message_layout();
        test_random_traffic();
        settle();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
